FILE: src/afa_pkg.sv
// Package for the attractor force accumulator: widths, defaults, state type.
// No dependencies.
package afa_pkg;
  localparam int LinesDef = 8;
  localparam int AttrsDef = 128;
  localparam logic [19:0] CutoffRst = 20'd300;
  localparam logic [31:0] StrengthRst = 32'd10000000;
  localparam logic [7:0] CountRst = 8'd70;
  localparam logic [1:0] CfgCutoff = 2'd0;
  localparam logic [1:0] CfgStrength = 2'd1;
  localparam logic [1:0] CfgCount = 2'd2;
  localparam logic KindLoad = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_DIFF, ST_MAG, ST_SQ, ST_SQRT, ST_DEN, ST_NUM, ST_DIV, ST_ACC, ST_OUT
  } afa_state_t;
endpackage

FILE: src/afa_if.sv
// Valid/ready channel interfaces for the accumulator.
// Depends on nothing.
interface afa_in_if;
  logic valid;
  logic ready;
  logic kind;
  logic [2:0] line;
  logic [6:0] slot;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  modport source (output valid, kind, line, slot, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, kind, line, slot, pos_x, pos_y, pos_z, output ready);
endinterface

interface afa_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] force_x;
  logic signed [31:0] force_y;
  logic signed [31:0] force_z;
  logic clipped;
  modport source (output valid, force_x, force_y, force_z, clipped, input ready);
  modport sink (input valid, force_x, force_y, force_z, clipped, output ready);
endinterface

FILE: src/afa_divider.sv
// Shared restoring divider: 96-bit numerator by 96-bit denominator, one bit per
// cycle, quotient saturated to 33 bits. Uses afa_pkg.
module afa_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [95:0] num,
  input  logic [95:0] den,
  output logic        done,
  output logic [32:0] quot
);
  import afa_pkg::*;
  logic [95:0] rem_r, rem_nxt, nsh_r, nsh_nxt, den_r;
  logic [96:0] trial;
  logic [95:0] q_r, q_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;

  always_comb begin
    trial = {rem_r, nsh_r[95]} - {1'b0, den_r};
    rem_nxt = rem_r;
    nsh_nxt = nsh_r;
    q_nxt = q_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt = '0;
      nsh_nxt = num;
      q_nxt = '0;
      cnt_nxt = 7'd96;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      nsh_nxt = {nsh_r[94:0], 1'b0};
      if (!trial[96]) begin
        rem_nxt = trial[95:0];
        q_nxt = {q_r[94:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[94:0], nsh_r[95]};
        q_nxt = {q_r[94:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    nsh_r <= nsh_nxt;
    q_r <= q_nxt;
    if (start) den_r <= den;
  end

  assign done = busy_r && (cnt_r == 7'd1);
  // Final quotient bit is in q_nxt on the done cycle.
  assign quot = (q_nxt[95:33] != '0 || q_nxt[32:0] > 33'h100000000) ?
                33'h100000000 : q_nxt[32:0];
endmodule

FILE: src/attractor_force_accumulator_unit.sv
// Attractor force accumulator, top level. Uses afa_pkg, afa_if, afa_divider.
// A load is written to the store when it is accepted; loads can follow back to back.
// A query visits each attractor in use; for each one beyond the cutoff and not at the
// far limit it takes a 31-step root, a two-step product and, per nonzero component,
// a divide on the 96-step shared divider. The result is registered in ST_OUT.
// Not ready while busy or while a result waits; synchronous active-low reset clears
// control and config, the store is not cleared.
module attractor_force_accumulator_unit #(
  parameter int LINES = afa_pkg::LinesDef,
  parameter int ATTRS = afa_pkg::AttrsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  afa_in_if.sink      in_ch,
  afa_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import afa_pkg::*;
  localparam int AW = (ATTRS > 1) ? $clog2(ATTRS) : 1;
  localparam int LW = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int DEPTH = LINES * ATTRS;
  localparam int MW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration registers
  logic [19:0] cutoff_r;
  logic [31:0] strength_r;
  logic [7:0]  count_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= CutoffRst;
      strength_r <= StrengthRst;
      count_r <= CountRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgCutoff:   cutoff_r <= cfg_data[19:0];
        CfgStrength: strength_r <= cfg_data;
        CfgCount:    count_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // attractor store, one write and one registered read port
  logic [95:0] mem [DEPTH];
  logic [95:0] rd_r;
  logic        we;
  logic [MW-1:0] waddr, raddr;
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= {in_ch.pos_x, in_ch.pos_y, in_ch.pos_z};
    rd_r <= mem[raddr];
  end

  afa_state_t st_r, st_nxt;
  logic [LW-1:0] line_r;
  logic [AW:0]   idx_r, lim_r;
  logic signed [31:0] p_r [3];
  logic signed [32:0] d_r [3];
  logic [31:0] mag_r [3];
  logic signed [32:0] acc_r [3];
  logic [31:0] fo_r [3];
  logic clip_r, oclip_r, ovalid_r;
  logic [61:0] s_r;           // sum of squares, below 3*2^60
  logic [61:0] sq_x_r;        // isqrt working value
  logic [61:0] sq_res_r;      // partial root, scaled; ends below 2^31
  logic [61:0] sq_bit_r;
  logic [95:0] den_r;
  logic [1:0]  comp_r;
  logic [5:0]  step_r;
  logic        div_start, div_done;
  logic [32:0] quot;

  assign in_ch.ready = (st_r == ST_IDLE) && !ovalid_r;
  wire acc_in = in_ch.valid && in_ch.ready;
  wire line_ok = ({29'd0, in_ch.line} < LINES);
  wire slot_ok = ({25'd0, in_ch.slot} < ATTRS);

  assign we = acc_in && (in_ch.kind == KindLoad) && line_ok && slot_ok;
  assign waddr = MW'(in_ch.line * ATTRS + in_ch.slot);
  assign raddr = MW'(line_r * ATTRS + idx_r[AW-1:0]);

  // one operand mux feeds the shared 32x32 multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  always_comb begin
    mul_a = mag_r[comp_r];
    mul_b = mag_r[comp_r];
    if (st_r == ST_DEN) begin
      // s * r in two halves: low word first, then the high word
      mul_a = (step_r == 6'd0) ? s_r[31:0] : {2'b0, s_r[61:32]};
      mul_b = sq_res_r[31:0];
    end else if (st_r == ST_NUM) begin
      mul_b = strength_r;
    end
  end
  assign mul_p = mul_a * mul_b;

  // numerator |D| * strength * 2^24 goes straight into the divider at start
  afa_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num({8'd0, mul_p, 24'd0}), .den(den_r),
    .done(div_done), .quot(quot)
  );

  wire far = (mag_r[0][31:30] != 2'b0) || (mag_r[1][31:30] != 2'b0) ||
             (mag_r[2][31:30] != 2'b0);
  wire [61:0] s_new = s_r + {2'b0, mul_p[59:0]};
  wire skip = far || (s_new <= {26'd0, cutoff_r, 16'd0});
  wire last_attr = ((idx_r + (AW+1)'(1)) == lim_r);
  wire [61:0] sq_t = sq_res_r + sq_bit_r;

  always_comb begin
    st_nxt = st_r;
    div_start = 1'b0;
    unique case (st_r)
      ST_IDLE: if (acc_in && in_ch.kind != KindLoad)
        st_nxt = (line_ok && count_r != 8'd0) ? ST_RD : ST_OUT;
      ST_RD:   st_nxt = ST_DIFF;
      ST_DIFF: st_nxt = ST_MAG;
      ST_MAG:  st_nxt = ST_SQ;
      ST_SQ:   if (comp_r == 2'd2) begin
        if (skip) st_nxt = last_attr ? ST_OUT : ST_RD;
        else st_nxt = ST_SQRT;
      end
      ST_SQRT: if (step_r == 6'd30) st_nxt = ST_DEN;
      ST_DEN:  if (step_r == 6'd1) st_nxt = ST_NUM;
      ST_NUM:  begin
        // zero component adds nothing: skip the divide
        if (mag_r[comp_r] == '0) begin
          st_nxt = ST_ACC;
        end else begin
          st_nxt = ST_DIV;
          div_start = 1'b1;
        end
      end
      ST_DIV:  if (div_done) st_nxt = ST_ACC;
      ST_ACC:  begin
        if (comp_r == 2'd2) st_nxt = last_attr ? ST_OUT : ST_RD;
        else st_nxt = ST_NUM;
      end
      ST_OUT:  st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // saturating add of one term
  logic signed [33:0] sum;
  always_comb begin
    sum = {acc_r[comp_r][32], acc_r[comp_r]} +
          (d_r[comp_r][32] ? -$signed({1'b0, quot}) : $signed({1'b0, quot}));
  end

  logic [32:0] ab [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ab[k] = d_r[k][32] ? 33'(-d_r[k]) : d_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_OUT) ovalid_r <= 1'b1;
      else if (out_ch.valid && out_ch.ready) ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      ST_IDLE: if (acc_in) begin
        line_r <= LW'(in_ch.line);
        idx_r <= '0;
        lim_r <= (count_r > ATTRS) ? (AW+1)'(ATTRS) : (AW+1)'(count_r);
        p_r[0] <= in_ch.pos_x;
        p_r[1] <= in_ch.pos_y;
        p_r[2] <= in_ch.pos_z;
        for (int k = 0; k < 3; k++) acc_r[k] <= '0;
        clip_r <= 1'b0;
      end
      ST_RD: ;
      ST_DIFF: begin
        d_r[0] <= $signed({rd_r[95], rd_r[95:64]}) - $signed({p_r[0][31], p_r[0]});
        d_r[1] <= $signed({rd_r[63], rd_r[63:32]}) - $signed({p_r[1][31], p_r[1]});
        d_r[2] <= $signed({rd_r[31], rd_r[31:0]}) - $signed({p_r[2][31], p_r[2]});
        s_r <= '0;
      end
      ST_MAG: begin
        // magnitudes, saturating at the far limit
        for (int k = 0; k < 3; k++)
          mag_r[k] <= (ab[k][32:30] != 3'd0) ? 32'hC000_0000 : ab[k][31:0];
        comp_r <= 2'd0;
      end
      ST_SQ: begin
        s_r <= s_new;
        if (comp_r == 2'd2) begin
          comp_r <= 2'd0;
          if (skip) begin
            idx_r <= idx_r + (AW+1)'(1);
          end else begin
            sq_x_r <= s_new;
            sq_res_r <= '0;
            sq_bit_r <= 62'd1 << 60;
            step_r <= '0;
          end
        end else begin
          comp_r <= comp_r + 2'd1;
        end
      end
      ST_SQRT: begin
        if (sq_x_r >= sq_t) begin
          sq_x_r <= sq_x_r - sq_t;
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
        step_r <= (step_r == 6'd30) ? 6'd0 : step_r + 6'd1;
      end
      ST_DEN: begin
        if (step_r == 6'd0) begin
          den_r <= {32'd0, mul_p};
          step_r <= 6'd1;
        end else begin
          den_r <= den_r + {mul_p, 32'd0};
          step_r <= 6'd0;
          comp_r <= 2'd0;
        end
      end
      ST_NUM: ;
      ST_DIV: ;
      ST_ACC: begin
        if (mag_r[comp_r] != '0) begin
          if (sum > 34'sd2147483647) begin
            acc_r[comp_r] <= 33'sd2147483647;
            clip_r <= 1'b1;
          end else if (sum < -34'sd2147483648) begin
            acc_r[comp_r] <= -33'sd2147483648;
            clip_r <= 1'b1;
          end else begin
            acc_r[comp_r] <= sum[32:0];
          end
        end
        if (comp_r == 2'd2) begin
          comp_r <= 2'd0;
          idx_r <= idx_r + (AW+1)'(1);
        end else begin
          comp_r <= comp_r + 2'd1;
        end
      end
      ST_OUT: begin
        for (int k = 0; k < 3; k++) fo_r[k] <= acc_r[k][31:0];
        oclip_r <= clip_r;
      end
      default: ;
    endcase
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.force_x = fo_r[0];
  assign out_ch.force_y = fo_r[1];
  assign out_ch.force_z = fo_r[2];
  assign out_ch.clipped = oclip_r;
endmodule
